FILE: rtl/well1024_pkg.sv
// Package for the WELL1024a generator: request codes, pool constants, seed mix.
// Used by well1024a_random_generator. No dependencies.

package well1024_pkg;

    localparam int POOL_WORDS_DEF = 32;

    // WELL1024a tap offsets relative to the current position
    localparam int OFF_M1 = 3;
    localparam int OFF_M2 = 24;
    localparam int OFF_M3 = 10;

    localparam logic [31:0] MIX_PRIME = 32'd524287;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

    typedef enum logic [1:0] {
        OP_SEED  = 2'd0,
        OP_RAW   = 2'd1,
        OP_RANGE = 2'd2
    } op_t;

    // seed fill: (prev ^ ((prev >> 30) + idx)) * 524287, modulo 2^32
    function automatic logic [31:0] seed_mix(input logic [31:0] prev, input logic [31:0] idx);
        logic [31:0] t;
        t = prev ^ ((prev >> 30) + idx);
        return t * MIX_PRIME;
    endfunction

endpackage

FILE: rtl/well1024a_random_generator.sv
// WELL1024a generator top level: pool memory, step sequencer and shared restoring divider.
// Depends on well1024_pkg.
//
//  channel  | dir | tdata                                       | tuser      | tlast
//  ---------+-----+---------------------------------------------+------------+----------
//  s_*      | in  | seed_word[31:0] range_min[63:32] max[95:64] | operation  | last_seed
//  m_*      | out | value[31:0]                                 | -          | -
//
// Seed word: written from S_IDLE; the word marked last adds one S_FILL write per unseeded pool entry.
// Raw draw: RD0, RD1, RD2, CALC and WR1, then OUT (three pool reads, two writes).
// Range draw: a divider pass, multiply, one WELL step (RD0 to WR1) per value tried, a second
// divider pass and OUT; an empty or single-value range goes straight to OUT, a full range
// takes a plain step. The two-read/one-write pool port and bit-serial divider set this order.
// One request at a time; the next is taken while a result still waits on m_*.
// Reset clears the pool valid bits at once, so no clearing pass is needed.

module well1024a_random_generator #(
    parameter int POOL_WORDS = well1024_pkg::POOL_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // seed_word, range_min, range_max
    input  logic [1:0]  s_tuser,   // operation
    input  logic        s_tlast,   // last_seed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // value
);

    localparam int IDX_W = $clog2(POOL_WORDS);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_FILL = 10'b00_0000_0010,
        S_RD0  = 10'b00_0000_0100,
        S_RD1  = 10'b00_0000_1000,
        S_RD2  = 10'b00_0001_0000,
        S_CALC = 10'b00_0010_0000,
        S_WR1  = 10'b00_0100_0000,
        S_DIV  = 10'b00_1000_0000,
        S_MUL  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // pool memory with per-entry valid bits
    logic [31:0]           mem [POOL_WORDS];
    logic [POOL_WORDS-1:0] valid_reg;
    logic [POOL_WORDS-1:0] wr_mask;
    logic [IDX_W-1:0]      rd_addr_a, rd_addr_b, wr_addr;
    logic                  wr_en;
    logic [31:0]           wr_data;
    logic [31:0]           rd_data_a_reg, rd_data_b_reg;
    logic                  rd_va_reg, rd_vb_reg;
    logic [31:0]           rd_a_word, rd_b_word;

    logic [IDX_W-1:0] pos_reg;
    logic [CNT_W-1:0] seed_count_reg;
    logic             seeding_reg;
    logic             mode_range_reg;

    logic [31:0] v0_reg, a_reg, b_reg, c_reg, nv0_reg, prev_reg;
    logic [31:0] lo_reg, span_reg, div_reg, limit_reg, res_reg;
    logic        res_add_reg;
    logic [31:0] rem_reg, quo_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_final_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    // request fields
    logic                 acc;
    well1024_pkg::op_t    op;
    logic [31:0]          in_word, in_lo, in_hi, in_span;
    logic [CNT_W-1:0]     cnt_eff, cnt_new;
    logic                 seed_room;

    // step datapath
    logic [31:0] z1, z2, nv1, nv0, fill_word;
    logic [IDX_W-1:0] pos_m1, pos_m2, pos_m3, pos_prev;

    // divider
    logic [31:0] div_den, div_rem_next;
    logic [32:0] div_shift;
    logic        div_ge;

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid & s_tready;
    assign op       = well1024_pkg::op_t'(s_tuser);
    assign in_word  = s_tdata[31:0];
    assign in_lo    = s_tdata[63:32];
    assign in_hi    = s_tdata[95:64];
    assign in_span  = in_hi - in_lo + 32'd1;

    assign cnt_eff   = seeding_reg ? seed_count_reg : '0;
    assign seed_room = (cnt_eff < CNT_W'(POOL_WORDS));
    assign cnt_new   = cnt_eff + CNT_W'(seed_room);

    assign pos_m1   = pos_reg + IDX_W'(well1024_pkg::OFF_M1);
    assign pos_m2   = pos_reg + IDX_W'(well1024_pkg::OFF_M2);
    assign pos_m3   = pos_reg + IDX_W'(well1024_pkg::OFF_M3);
    assign pos_prev = pos_reg + IDX_W'(POOL_WORDS - 1);

    assign rd_a_word = rd_va_reg ? rd_data_a_reg : '0;
    assign rd_b_word = rd_vb_reg ? rd_data_b_reg : '0;

    // CALC: v0..c held, w arrives on read port A
    assign z1  = v0_reg ^ a_reg ^ (a_reg >> 8);
    assign z2  = b_reg ^ (b_reg << 19) ^ c_reg ^ (c_reg << 14);
    assign nv1 = z1 ^ z2;
    assign nv0 = rd_a_word ^ (rd_a_word << 11) ^ z1 ^ (z1 << 7) ^ z2 ^ (z2 << 13);

    assign fill_word = well1024_pkg::seed_mix(prev_reg, 32'(seed_count_reg));

    assign div_den      = div_final_reg ? div_reg : span_reg;
    assign div_shift    = {rem_reg, quo_reg[31]};
    assign div_ge       = (div_shift >= {1'b0, div_den});
    assign div_rem_next = div_ge ? 32'(div_shift - {1'b0, div_den}) : div_shift[31:0];

    assign wr_mask = wr_en ? (POOL_WORDS'(1) << wr_addr) : '0;

    always_comb
    begin
        rd_addr_a = pos_reg;
        rd_addr_b = pos_m1;
        case (state_reg)
            S_RD1:
            begin
                rd_addr_a = pos_m2;
                rd_addr_b = pos_m3;
            end
            S_RD2:
            begin
                rd_addr_a = pos_prev;
            end
            default:
            begin
                rd_addr_a = pos_reg;
                rd_addr_b = pos_m1;
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = nv1;
        case (state_reg)
            S_IDLE:
            begin
                wr_en   = acc && (op == well1024_pkg::OP_SEED) && seed_room;
                wr_addr = cnt_eff[IDX_W-1:0];
                wr_data = in_word;
            end
            S_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = seed_count_reg[IDX_W-1:0];
                wr_data = fill_word;
            end
            S_CALC:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = nv1;
            end
            S_WR1:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_prev;
                wr_data = nv0_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (op)
                        well1024_pkg::OP_SEED:
                            state_next = (s_tlast && (cnt_new < CNT_W'(POOL_WORDS))) ? S_FILL
                                                                                   : S_IDLE;
                        well1024_pkg::OP_RAW:
                            state_next = S_RD0;
                        well1024_pkg::OP_RANGE:
                        begin
                            if ((in_lo >= in_hi))
                                state_next = S_OUT;
                            else if (in_span == 32'd0)
                                state_next = S_RD0;
                            else
                                state_next = S_DIV;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_FILL:
                state_next = (seed_count_reg == CNT_W'(POOL_WORDS - 1)) ? S_IDLE : S_FILL;
            S_RD0:
                state_next = S_RD1;
            S_RD1:
                state_next = S_RD2;
            S_RD2:
                state_next = S_CALC;
            S_CALC:
                state_next = S_WR1;
            S_WR1:
            begin
                if (!mode_range_reg)
                    state_next = S_OUT;
                else if (nv0_reg >= limit_reg)
                    state_next = S_RD0;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == 5'd31)
                    state_next = div_final_reg ? S_OUT : S_MUL;
            end
            S_MUL:
                state_next = S_RD0;
            S_OUT:
                state_next = (!m_tvalid_reg || m_tready) ? S_IDLE : S_OUT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // pool storage: two registered reads, one write
    always_ff @(posedge clk)
    begin
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            rd_va_reg      <= 1'b0;
            rd_vb_reg      <= 1'b0;
            pos_reg        <= '0;
            seed_count_reg <= '0;
            seeding_reg    <= 1'b0;
            mode_range_reg <= 1'b0;
            v0_reg         <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            nv0_reg        <= '0;
            prev_reg       <= '0;
            lo_reg         <= '0;
            span_reg       <= '0;
            div_reg        <= '0;
            limit_reg      <= '0;
            res_reg        <= '0;
            res_add_reg    <= 1'b0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            div_cnt_reg    <= '0;
            div_final_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rd_va_reg <= valid_reg[rd_addr_a];
            rd_vb_reg <= valid_reg[rd_addr_b];

            // first word of a sequence empties the pool; a write marks its entry
            if (acc && (op == well1024_pkg::OP_SEED) && !seeding_reg)
                valid_reg <= wr_mask;
            else
                valid_reg <= valid_reg | wr_mask;

            if ((state_reg == S_OUT) && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        case (op)
                            well1024_pkg::OP_SEED:
                            begin
                                if (!seeding_reg)
                                    pos_reg <= '0;
                                seed_count_reg <= cnt_new;
                                seeding_reg    <= !s_tlast;
                                prev_reg       <= in_word;
                            end
                            well1024_pkg::OP_RAW:
                            begin
                                mode_range_reg <= 1'b0;
                            end
                            well1024_pkg::OP_RANGE:
                            begin
                                lo_reg         <= in_lo;
                                span_reg       <= in_span;
                                res_add_reg    <= 1'b0;
                                res_reg        <= (in_lo > in_hi) ? 32'd0 : in_lo;
                                // full range falls back to a plain step
                                mode_range_reg <= (in_span != 32'd0);
                                rem_reg        <= '0;
                                quo_reg        <= well1024_pkg::ALL_ONES;
                                div_cnt_reg    <= '0;
                                div_final_reg  <= 1'b0;
                            end
                            default:
                            begin
                                mode_range_reg <= mode_range_reg;
                            end
                        endcase
                    end
                end
                S_FILL:
                begin
                    // seed_count doubles as the fill index; it is unused once seeding ends
                    prev_reg       <= fill_word;
                    seed_count_reg <= seed_count_reg + CNT_W'(1);
                end
                S_RD1:
                begin
                    v0_reg <= rd_a_word;
                    a_reg  <= rd_b_word;
                end
                S_RD2:
                begin
                    b_reg <= rd_a_word;
                    c_reg <= rd_b_word;
                end
                S_CALC:
                begin
                    nv0_reg <= nv0;
                end
                S_WR1:
                begin
                    pos_reg <= pos_prev;
                    if (!mode_range_reg)
                    begin
                        res_reg     <= nv0_reg;
                        res_add_reg <= 1'b0;
                    end
                    else if (nv0_reg < limit_reg)
                    begin
                        rem_reg       <= '0;
                        quo_reg       <= nv0_reg;
                        div_cnt_reg   <= '0;
                        div_final_reg <= 1'b1;
                        res_add_reg   <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= div_rem_next;
                    quo_reg     <= {quo_reg[30:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                end
                S_MUL:
                begin
                    div_reg   <= quo_reg;
                    limit_reg <= 32'(quo_reg * span_reg);
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                        m_tdata_reg <= res_add_reg ? (lo_reg + quo_reg) : res_reg;
                end
                default:
                begin
                    div_cnt_reg <= div_cnt_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // fill only runs once the sequence is closed and within the pool
    a_fill_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (!seeding_reg && (seed_count_reg < CNT_W'(POOL_WORDS))))
        else $error("fill pass outside a closed seed sequence");

    // rejection loop needs a non-zero limit or it never ends
    a_limit_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD0 && mode_range_reg && $past(state_reg) == S_MUL) |-> (limit_reg != 0))
        else $error("range draw started with zero limit");

    // scaling division must have a non-zero divisor
    a_div_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_den != 32'd0))
        else $error("divider running with zero divisor");

    // a result held on the output is never overwritten before it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("pending result lost or changed");

endmodule
